FILE: rtl/bqrs_pkg.sv
`default_nettype none

package bqrs_pkg;

    localparam int HOLD_COUNT_BITS_DEF = 8;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int CODE_W = 7;
    localparam int LPS_W  = 8;

    localparam logic [IDX_W-1:0] REG_LONG_PRESS = 3'd0;
    localparam logic [IDX_W-1:0] REG_CODE_BYP   = 3'd1;
    localparam logic [IDX_W-1:0] REG_CODE_TUN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_CODE_LA    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CODE_LB    = 3'd4;

    localparam logic [LPS_W-1:0]  LONG_PRESS_RST = 8'd96;
    localparam logic [CODE_W-1:0] CODE_BYP_RST   = 7'h2B;
    localparam logic [CODE_W-1:0] CODE_TUN_RST   = 7'h4A;
    localparam logic [CODE_W-1:0] CODE_LA_RST    = 7'h32;
    localparam logic [CODE_W-1:0] CODE_LB_RST    = 7'h2C;

    localparam logic [1:0] MODE_BYPASS = 2'd0;
    localparam logic [1:0] MODE_TUNER  = 2'd1;
    localparam logic [1:0] MODE_LINE   = 2'd2;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_BYPASS = 2'd1;
    localparam logic [1:0] EV_LINE   = 2'd2;
    localparam logic [1:0] EV_LONG   = 2'd3;

    localparam int KEY_BYP  = 0;
    localparam int KEY_LINE = 1;

    typedef struct packed {
        logic [LPS_W-1:0]  long_press_scans;
        logic [CODE_W-1:0] code_bypass;
        logic [CODE_W-1:0] code_tuner;
        logic [CODE_W-1:0] code_line_a;
        logic [CODE_W-1:0] code_line_b;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0] route_code;
        logic              led_bypass;
        logic              led_tuner;
        logic              led_line_a;
        logic              led_line_b;
        logic [1:0]        mode_now;
        logic [1:0]        event_res;
        logic              updated;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/bqrs_cfg.sv
`default_nettype none

module bqrs_cfg
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bqrs_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [bqrs_pkg::DATA_W-1:0]   pwdata,
    output logic      [bqrs_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output bqrs_pkg::cfg_t                     cfg
);

    bqrs_pkg::cfg_t              cfg_reg;
    bqrs_pkg::cfg_t              cfg_next;
    logic [bqrs_pkg::IDX_W-1:0]  idx;
    logic                        wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[bqrs_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                bqrs_pkg::REG_LONG_PRESS:
                    cfg_next.long_press_scans = pwdata[bqrs_pkg::LPS_W-1:0];
                bqrs_pkg::REG_CODE_BYP: cfg_next.code_bypass = pwdata[bqrs_pkg::CODE_W-1:0];
                bqrs_pkg::REG_CODE_TUN: cfg_next.code_tuner  = pwdata[bqrs_pkg::CODE_W-1:0];
                bqrs_pkg::REG_CODE_LA:  cfg_next.code_line_a = pwdata[bqrs_pkg::CODE_W-1:0];
                bqrs_pkg::REG_CODE_LB:  cfg_next.code_line_b = pwdata[bqrs_pkg::CODE_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bqrs_pkg::REG_LONG_PRESS:
                prdata = {{(bqrs_pkg::DATA_W-bqrs_pkg::LPS_W){1'b0}}, cfg_reg.long_press_scans};
            bqrs_pkg::REG_CODE_BYP:
                prdata = {{(bqrs_pkg::DATA_W-bqrs_pkg::CODE_W){1'b0}}, cfg_reg.code_bypass};
            bqrs_pkg::REG_CODE_TUN:
                prdata = {{(bqrs_pkg::DATA_W-bqrs_pkg::CODE_W){1'b0}}, cfg_reg.code_tuner};
            bqrs_pkg::REG_CODE_LA:
                prdata = {{(bqrs_pkg::DATA_W-bqrs_pkg::CODE_W){1'b0}}, cfg_reg.code_line_a};
            bqrs_pkg::REG_CODE_LB:
                prdata = {{(bqrs_pkg::DATA_W-bqrs_pkg::CODE_W){1'b0}}, cfg_reg.code_line_b};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_scans <= bqrs_pkg::LONG_PRESS_RST;
            cfg_reg.code_bypass      <= bqrs_pkg::CODE_BYP_RST;
            cfg_reg.code_tuner       <= bqrs_pkg::CODE_TUN_RST;
            cfg_reg.code_line_a      <= bqrs_pkg::CODE_LA_RST;
            cfg_reg.code_line_b      <= bqrs_pkg::CODE_LB_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/bqrs_scan.sv
`default_nettype none

module bqrs_scan
#(
    parameter int HOLD_COUNT_BITS = bqrs_pkg::HOLD_COUNT_BITS_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire logic           bypass_pin,
    input  wire logic           line_pin,
    input  wire bqrs_pkg::cfg_t cfg,
    output bqrs_pkg::res_t      res
);

    localparam int CMP_W = (HOLD_COUNT_BITS > bqrs_pkg::LPS_W) ? HOLD_COUNT_BITS
                                                               : bqrs_pkg::LPS_W;
    localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = '1;

    logic [1:0]                 last_reg,   last_next;
    logic [1:0]                 stable_reg, stable_next;
    logic [1:0]                 pend_reg,   pend_next;
    logic [HOLD_COUNT_BITS-1:0] hold_reg,   hold_next;
    logic [1:0]                 mode_reg,   mode_next;
    logic                       choice_reg, choice_next;

    logic [1:0]                 sample;
    logic [1:0]                 rise;
    logic [1:0]                 pend_db;
    logic [HOLD_COUNT_BITS-1:0] hold_inc;
    logic [1:0]                 ev;
    logic [1:0]                 m_cur;

    // debounce and edge capture
    always_comb
    begin
        sample      = {~line_pin, ~bypass_pin};
        rise        = ~stable_reg & sample;
        stable_next = stable_reg;
        pend_db     = pend_reg;
        if (sample == last_reg)
        begin
            stable_next = sample;
            if (rise != 2'b00)
            begin
                pend_db = rise;
            end
        end
        last_next = sample;
    end

    // command check
    always_comb
    begin
        hold_inc  = (hold_reg == HOLD_MAX) ? hold_reg : hold_reg + 1'b1;
        ev        = bqrs_pkg::EV_NONE;
        pend_next = pend_db;
        hold_next = '0;
        if (stable_next[bqrs_pkg::KEY_BYP])
        begin
            hold_next = hold_inc;
            if (CMP_W'(hold_inc) > CMP_W'(cfg.long_press_scans))
            begin
                ev        = bqrs_pkg::EV_LONG;
                pend_next = 2'b00;
            end
        end
        else
        begin
            priority if (pend_db[bqrs_pkg::KEY_LINE])
            begin
                ev        = bqrs_pkg::EV_LINE;
                pend_next = 2'b00;
            end
            else if (pend_db[bqrs_pkg::KEY_BYP])
            begin
                ev        = bqrs_pkg::EV_BYPASS;
                pend_next = 2'b00;
            end
            else
            begin
                ev        = bqrs_pkg::EV_NONE;
            end
        end
    end

    // mode selector
    always_comb
    begin
        m_cur       = (mode_reg == bqrs_pkg::MODE_TUNER || mode_reg == bqrs_pkg::MODE_LINE)
                      ? mode_reg : bqrs_pkg::MODE_BYPASS;
        mode_next   = m_cur;
        choice_next = choice_reg;
        if (ev != bqrs_pkg::EV_NONE)
        begin
            unique case (m_cur)
                bqrs_pkg::MODE_TUNER:
                begin
                    if (ev == bqrs_pkg::EV_BYPASS)
                        mode_next = bqrs_pkg::MODE_BYPASS;
                    else if (ev == bqrs_pkg::EV_LINE)
                        mode_next = bqrs_pkg::MODE_LINE;
                end
                bqrs_pkg::MODE_LINE:
                begin
                    if (ev == bqrs_pkg::EV_BYPASS)
                        mode_next = bqrs_pkg::MODE_BYPASS;
                    else if (ev == bqrs_pkg::EV_LONG)
                        mode_next = bqrs_pkg::MODE_TUNER;
                    else
                        choice_next = ~choice_reg;
                end
                default:
                begin
                    mode_next = (ev == bqrs_pkg::EV_LONG) ? bqrs_pkg::MODE_TUNER
                                                           : bqrs_pkg::MODE_LINE;
                end
            endcase
        end
    end

    // result word
    always_comb
    begin
        res.led_bypass = (mode_next == bqrs_pkg::MODE_BYPASS);
        res.led_tuner  = (mode_next == bqrs_pkg::MODE_TUNER);
        res.led_line_a = (mode_next == bqrs_pkg::MODE_LINE) && !choice_next;
        res.led_line_b = (mode_next == bqrs_pkg::MODE_LINE) && choice_next;
        res.mode_now   = mode_next;
        res.event_res  = ev;
        res.updated    = (ev != bqrs_pkg::EV_NONE);
        if (mode_next == bqrs_pkg::MODE_BYPASS)
            res.route_code = cfg.code_bypass;
        else if (mode_next == bqrs_pkg::MODE_TUNER)
            res.route_code = cfg.code_tuner;
        else
            res.route_code = choice_next ? cfg.code_line_b : cfg.code_line_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= 2'b00;
            stable_reg <= 2'b00;
            pend_reg   <= 2'b00;
            hold_reg   <= '0;
            mode_reg   <= bqrs_pkg::MODE_BYPASS;
            choice_reg <= 1'b0;
        end
        else if (fire)
        begin
            last_reg   <= last_next;
            stable_reg <= stable_next;
            pend_reg   <= pend_next;
            hold_reg   <= hold_next;
            mode_reg   <= mode_next;
            choice_reg <= choice_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/button_qualified_route_selector.sv
// channel  | handshake                | payload
// ---------+--------------------------+------------------------------------------------
// scan     | scan_valid / scan_stall  | bypass_pin, line_pin
// result   | res_valid / res_stall    | route_code, led_*, mode_now, event_res, updated
// config   | apb psel/penable/pready  | paddr, pwdata, prdata
//
// one request per clock sustained while the result is not stalled; a scan goes
// through the input register, then scan logic into the result register
// reset clears debounce state, hold counter, mode and line choice; registers
// take their default codes
// a stalled result holds the result register; the input register drains into it
// as soon as it frees, and scan_stall rises only while both are occupied
`default_nettype none

module button_qualified_route_selector
#(
    parameter int HOLD_COUNT_BITS = bqrs_pkg::HOLD_COUNT_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          scan_valid,
    output logic                               scan_stall,
    input  wire logic                          bypass_pin,
    input  wire logic                          line_pin,

    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic [bqrs_pkg::CODE_W-1:0]        route_code,
    output logic                               led_bypass,
    output logic                               led_tuner,
    output logic                               led_line_a,
    output logic                               led_line_b,
    output logic [1:0]                         mode_now,
    output logic [1:0]                         event_res,
    output logic                               updated,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bqrs_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [bqrs_pkg::DATA_W-1:0]   pwdata,
    output logic      [bqrs_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    bqrs_pkg::cfg_t  cfg;
    bqrs_pkg::res_t  res_comb;
    bqrs_pkg::res_t  res_reg;

    logic in_valid_reg,  in_valid_next;
    logic byp_pin_reg;
    logic line_pin_reg;
    logic out_valid_reg, out_valid_next;
    logic accept;
    logic advance;

    assign advance    = in_valid_reg && (!out_valid_reg || !res_stall);
    assign scan_stall = in_valid_reg && !advance;
    assign accept     = scan_valid && !scan_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!res_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byp_pin_reg  <= bypass_pin;
            line_pin_reg <= line_pin;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    bqrs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bqrs_scan #(
        .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
    ) u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .bypass_pin (byp_pin_reg),
        .line_pin   (line_pin_reg),
        .cfg        (cfg),
        .res        (res_comb)
    );

    assign res_valid  = out_valid_reg;
    assign route_code = res_reg.route_code;
    assign led_bypass = res_reg.led_bypass;
    assign led_tuner  = res_reg.led_tuner;
    assign led_line_a = res_reg.led_line_a;
    assign led_line_b = res_reg.led_line_b;
    assign mode_now   = res_reg.mode_now;
    assign event_res  = res_reg.event_res;
    assign updated    = res_reg.updated;

endmodule

`default_nettype wire

FILE: sim/route_selector_check.sv
module route_selector_check
    import bqrs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              scan_valid,
    input  wire logic              scan_stall,
    input  wire logic              bypass_pin,
    input  wire logic              line_pin,
    input  wire logic              res_valid,
    input  wire logic              res_stall,
    input  wire logic [CODE_W-1:0] route_code,
    input  wire logic              led_bypass,
    input  wire logic              led_tuner,
    input  wire logic              led_line_a,
    input  wire logic              led_line_b,
    input  wire logic [1:0]        mode_now,
    input  wire logic [1:0]        event_res,
    input  wire logic              updated,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    input  wire logic [DATA_W-1:0] prdata,
    input  wire logic              pready,
    output int                     mismatches,
    output int                     outstanding,
    output int                     results_checked,
    output int                     commands_seen,
    output int                     long_cmds
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_W = HOLD_COUNT_BITS_DEF;

    cfg_t              cfg;
    logic [1:0]        last_keys;
    logic [1:0]        stable_keys;
    logic [1:0]        pending_keys;
    logic [HOLD_W-1:0] held_scans;
    logic [1:0]        mode;
    logic              line_b;
    res_t              route_due[$];
    int                fail_cnt;
    int                result_cnt;
    int                cmd_cnt;
    int                long_cnt;

    // one scan: debounce, command check, mode update
    function automatic res_t scan_route(input logic bp, input logic lp);
        logic [1:0] keys;
        logic [1:0] rise;
        logic [1:0] cmd;
        logic [1:0] m;
        res_t       r;
        keys = '0;
        keys[KEY_BYP] = ~bp;
        keys[KEY_LINE] = ~lp;
        if (keys == last_keys)
        begin
            rise = (stable_keys ^ keys) & keys;
            stable_keys = keys;
            if (rise != 2'b00)
                pending_keys = rise;
        end
        last_keys = keys;

        cmd = EV_NONE;
        if (stable_keys[KEY_BYP])
        begin
            if (held_scans != '1)
                held_scans = held_scans + 1'b1;
            if (held_scans > cfg.long_press_scans)
            begin
                cmd = EV_LONG;
                pending_keys = '0;
            end
        end
        else
        begin
            held_scans = '0;
            if (pending_keys[KEY_LINE])
            begin
                cmd = EV_LINE;
                pending_keys = '0;
            end
            else if (pending_keys[KEY_BYP])
            begin
                cmd = EV_BYPASS;
                pending_keys = '0;
            end
        end

        m = (mode == MODE_TUNER || mode == MODE_LINE) ? mode : MODE_BYPASS;
        if (cmd != EV_NONE)
        begin
            case (m)
                MODE_BYPASS:
                    m = (cmd == EV_LONG) ? MODE_TUNER : MODE_LINE;
                MODE_TUNER:
                begin
                    if (cmd == EV_BYPASS)
                        m = MODE_BYPASS;
                    else if (cmd == EV_LINE)
                        m = MODE_LINE;
                end
                default:
                begin
                    if (cmd == EV_BYPASS)
                        m = MODE_BYPASS;
                    else if (cmd == EV_LONG)
                        m = MODE_TUNER;
                    else
                        line_b = ~line_b;
                end
            endcase
        end
        mode = m;

        if (m == MODE_BYPASS)
            r.route_code = cfg.code_bypass;
        else if (m == MODE_TUNER)
            r.route_code = cfg.code_tuner;
        else
            r.route_code = line_b ? cfg.code_line_b : cfg.code_line_a;
        r.led_bypass = (m == MODE_BYPASS);
        r.led_tuner  = (m == MODE_TUNER);
        r.led_line_a = (m == MODE_LINE) && !line_b;
        r.led_line_b = (m == MODE_LINE) && line_b;
        r.mode_now   = m;
        r.event_res  = cmd;
        r.updated    = (cmd != EV_NONE);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] reg_word(input logic [IDX_W-1:0] idx);
        case (idx)
            REG_LONG_PRESS: return DATA_W'(cfg.long_press_scans);
            REG_CODE_BYP:   return DATA_W'(cfg.code_bypass);
            REG_CODE_TUN:   return DATA_W'(cfg.code_tuner);
            REG_CODE_LA:    return DATA_W'(cfg.code_line_a);
            REG_CODE_LB:    return DATA_W'(cfg.code_line_b);
            default:        return '0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        logic [DATA_W-1:0] reg_exp;
        if (!rst_n)
        begin
            cfg.long_press_scans = LONG_PRESS_RST;
            cfg.code_bypass      = CODE_BYP_RST;
            cfg.code_tuner       = CODE_TUN_RST;
            cfg.code_line_a      = CODE_LA_RST;
            cfg.code_line_b      = CODE_LB_RST;
            last_keys    = '0;
            stable_keys  = '0;
            pending_keys = '0;
            held_scans   = '0;
            mode         = MODE_BYPASS;
            line_b       = 1'b0;
            route_due.delete();
            fail_cnt   = 0;
            result_cnt = 0;
            cmd_cnt    = 0;
            long_cnt   = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[ADDR_W-1:2])
                        REG_LONG_PRESS: cfg.long_press_scans = pwdata[LPS_W-1:0];
                        REG_CODE_BYP:   cfg.code_bypass      = pwdata[CODE_W-1:0];
                        REG_CODE_TUN:   cfg.code_tuner       = pwdata[CODE_W-1:0];
                        REG_CODE_LA:    cfg.code_line_a      = pwdata[CODE_W-1:0];
                        REG_CODE_LB:    cfg.code_line_b      = pwdata[CODE_W-1:0];
                        default: ;
                    endcase
                end
                else
                begin
                    reg_exp = reg_word(paddr[ADDR_W-1:2]);
                    if (prdata !== reg_exp)
                    begin
                        if (fail_cnt < 10)
                            $display("register read at %h: expected %h, got %h",
                                     paddr, reg_exp, prdata);
                        fail_cnt++;
                    end
                end
            end

            if (scan_valid && !scan_stall)
                route_due.push_back(scan_route(bypass_pin, line_pin));

            if (res_valid && !res_stall)
            begin
                got = {route_code, led_bypass, led_tuner, led_line_a, led_line_b,
                       mode_now, event_res, updated};
                result_cnt++;
                if (got.updated)
                    cmd_cnt++;
                if (got.event_res == EV_LONG)
                    long_cnt++;
                if (route_due.size() == 0)
                begin
                    if (fail_cnt < 10)
                        $display("result %0d arrived with no request waiting", result_cnt);
                    fail_cnt++;
                end
                else
                begin
                    want = route_due.pop_front();
                    if (got !== want)
                    begin
                        if (fail_cnt < 10)
                            $display({"result %0d: expected code %h leds %b mode %0d cmd %0d ",
                                      "upd %b, got code %h leds %b mode %0d cmd %0d upd %b"},
                                     result_cnt, want.route_code,
                                     {want.led_bypass, want.led_tuner,
                                      want.led_line_a, want.led_line_b},
                                     want.mode_now, want.event_res, want.updated,
                                     got.route_code,
                                     {got.led_bypass, got.led_tuner,
                                      got.led_line_a, got.led_line_b},
                                     got.mode_now, got.event_res, got.updated);
                        fail_cnt++;
                    end
                end
            end
        end
        mismatches      <= fail_cnt;
        outstanding     <= route_due.size();
        results_checked <= result_cnt;
        commands_seen   <= cmd_cnt;
        long_cmds       <= long_cnt;
    end

endmodule

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bqrs_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              scan_valid = 1'b0;
    logic              scan_stall;
    logic              bypass_pin = 1'b1;
    logic              line_pin = 1'b1;
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic [CODE_W-1:0] route_code;
    logic              led_bypass;
    logic              led_tuner;
    logic              led_line_a;
    logic              led_line_b;
    logic [1:0]        mode_now;
    logic [1:0]        event_res;
    logic              updated;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int mismatches;
    int outstanding;
    int results_checked;
    int commands_seen;
    int long_cmds;

    int sender_idle_pct = 0;
    int stall_pct = 0;
    int scans_sent = 0;
    int quiet_cycles = 0;

    button_qualified_route_selector i_dut (.*);

    route_selector_check i_check (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((scan_valid && !scan_stall) || (res_valid && !res_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic send_scan(input logic bp, input logic lp);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            scan_valid <= 1'b0;
            @(posedge clk);
        end
        scan_valid <= 1'b1;
        bypass_pin <= bp;
        line_pin   <= lp;
        @(posedge clk);
        while (scan_stall)
            @(posedge clk);
        scans_sent++;
    endtask

    task automatic hold_pins(input logic bp, input logic lp, input int n);
        repeat (n)
            send_scan(bp, lp);
    endtask

    task automatic drain();
        scan_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic reg_access(input logic wr, input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_all();
        reg_access(1'b0, REG_LONG_PRESS, '0);
        reg_access(1'b0, REG_CODE_BYP, '0);
        reg_access(1'b0, REG_CODE_TUN, '0);
        reg_access(1'b0, REG_CODE_LA, '0);
        reg_access(1'b0, REG_CODE_LB, '0);
    endtask

    // unused upper data bits carry noise
    task automatic set_config(input logic [LPS_W-1:0] lps, input logic [CODE_W-1:0] cb,
                              input logic [CODE_W-1:0] ct, input logic [CODE_W-1:0] ca,
                              input logic [CODE_W-1:0] cl);
        reg_access(1'b1, REG_LONG_PRESS, ($urandom() & ~32'hFF) | DATA_W'(lps));
        reg_access(1'b1, REG_CODE_BYP, ($urandom() & ~32'h7F) | DATA_W'(cb));
        reg_access(1'b1, REG_CODE_TUN, ($urandom() & ~32'h7F) | DATA_W'(ct));
        reg_access(1'b1, REG_CODE_LA, ($urandom() & ~32'h7F) | DATA_W'(ca));
        reg_access(1'b1, REG_CODE_LB, ($urandom() & ~32'h7F) | DATA_W'(cl));
        read_all();
    endtask

    task automatic random_gesture(input int lps);
        int kind;
        int held;
        int gap;
        kind = $urandom_range(99);
        if ($urandom_range((lps > 100) ? 24 : 7) == 0)
            held = lps - 2 + $urandom_range(8);
        else
            held = 2 + $urandom_range(6);
        if (held < 1)
            held = 1;
        gap = 2 + $urandom_range(3);
        if (kind < 35)
        begin
            hold_pins(1'b0, 1'b1, held);
            hold_pins(1'b1, 1'b1, gap);
        end
        else if (kind < 60)
        begin
            hold_pins(1'b1, 1'b0, held);
            hold_pins(1'b1, 1'b1, gap);
        end
        else if (kind < 70)
        begin
            hold_pins(1'b0, 1'b0, held);
            hold_pins(1'b1, 1'b1, gap);
        end
        else if (kind < 80)
        begin
            // line pressed while bypass held, then bypass let go first
            hold_pins(1'b0, 1'b1, 1 + $urandom_range(3));
            hold_pins(1'b0, 1'b0, held);
            hold_pins(1'b1, 1'b0, 2 + $urandom_range(3));
            hold_pins(1'b1, 1'b1, gap);
        end
        else if (kind < 90)
        begin
            repeat (1 + $urandom_range(5))
                send_scan(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        else
        begin
            // contact bounce
            repeat (2 + $urandom_range(4))
            begin
                send_scan(1'($urandom_range(1)), 1'b1);
                send_scan(1'b1, 1'($urandom_range(1)));
            end
            hold_pins(1'b1, 1'b1, gap);
        end
    endtask

    task automatic run_phase(input logic [LPS_W-1:0] lps, input int idle_pct,
                             input int stall_at, input int n);
        int stop_at;
        set_config(lps, CODE_W'($urandom_range(127)), CODE_W'($urandom_range(127)),
                   CODE_W'($urandom_range(127)), CODE_W'($urandom_range(127)));
        sender_idle_pct = idle_pct;
        stall_pct = stall_at;
        stop_at = scans_sent + n;
        while (scans_sent < stop_at)
            random_gesture(int'(lps));
        drain();
    endtask

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults
        read_all();
        sender_idle_pct = 30;
        stall_pct = 80;
        hold_pins(1'b1, 1'b1, 2);
        hold_pins(1'b0, 1'b1, 2);
        hold_pins(1'b1, 1'b1, 2);
        hold_pins(1'b1, 1'b0, 2);
        hold_pins(1'b1, 1'b1, 2);
        send_scan(1'b0, 1'b1);
        send_scan(1'b1, 1'b1);
        hold_pins(1'b0, 1'b0, 2);
        hold_pins(1'b1, 1'b1, 2);
        drain();

        // long press threshold of one scan, code extremes
        set_config(8'd1, 7'h00, 7'h7F, 7'h55, 7'h2A);
        hold_pins(1'b0, 1'b1, 4);
        hold_pins(1'b1, 1'b1, 2);
        hold_pins(1'b1, 1'b0, 2);
        hold_pins(1'b1, 1'b1, 2);
        hold_pins(1'b0, 1'b1, 2);
        hold_pins(1'b1, 1'b1, 1);
        drain();

        run_phase(8'd254, 30, 80, 120);
        run_phase(8'd1, 30, 80, 220);
        run_phase(LPS_W'(2 + $urandom_range(18)), 80, 30, 220);
        run_phase(LPS_W'(40 + $urandom_range(80)), 80, 30, 220);
        run_phase(LPS_W'(1 + $urandom_range(7)), 0, 0, 280);
        run_phase(8'd254, 0, 0, 120);
        repeat (4)
            @(posedge clk);

        $display("scan requests %0d, results checked %0d, commands %0d, long presses %0d",
                 scans_sent, results_checked, commands_seen, long_cmds);
        $display("thresholds 1 to 254 with random route codes under three idling patterns");
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
